// ----- design/rtis_pkg.sv -----
// ============================================================================
// rtis_pkg
// Shared types and constants for the rigid transform inlier scoring unit.
// ============================================================================
package rtis_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS     = 16;
  localparam int COORD_W       = 32;
  localparam int ENTRY_W       = 18;
  localparam int ROW_W         = 3 * ENTRY_W;
  localparam int SQ_W          = 32;
  localparam int SUM_W         = 42;
  localparam int PAIR_IDX_W    = 10;
  localparam int TOTAL_W       = 11;
  localparam int RATIO_W       = 17;
  localparam int RATIO_SHIFT   = 16;

  // Datapath widths: 3 products of 18x32 plus rounding, then shift and offsets
  localparam int ACC_W         = 53;
  localparam int DIF_W         = 55;
  localparam int PROD_W        = 2 * COORD_W;
  localparam int SQSUM_W       = PROD_W + 2;

  // Square root operand is the squared distance scaled back up
  localparam int ROOT_IN_W     = SQ_W + FRAC_BITS;

  // Defaults and sizes
  localparam int DEF_MAX_PAIRS = 1024;
  localparam int QUEUE_DEPTH   = 2;

  // Configuration port
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = ROW_W;

  localparam logic [ROW_W-1:0] ROT0_RST = ROW_W'(64'd65536);
  localparam logic [ROW_W-1:0] ROT1_RST = ROW_W'(64'd65536 << ENTRY_W);
  localparam logic [ROW_W-1:0] ROT2_RST = ROW_W'(64'd65536 << (2 * ENTRY_W));
  localparam logic [SQ_W-1:0]  MAX_ERR_SQ_RST = SQ_W'(164);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW0   = 3'd0,
    REG_ROT_ROW1   = 3'd1,
    REG_ROT_ROW2   = 3'd2,
    REG_SHIFT_X    = 3'd3,
    REG_SHIFT_Y    = 3'd4,
    REG_SHIFT_Z    = 3'd5,
    REG_MAX_ERR_SQ = 3'd6
  } rtis_reg_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [2:0][ROW_W-1:0]   rot;
    logic [2:0][COORD_W-1:0] shift;
    logic [SQ_W-1:0]         max_err_sq;
  } rtis_cfg_t;

  // Input beat
  typedef struct packed {
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic signed [COORD_W-1:0] src_z;
    logic signed [COORD_W-1:0] dst_x;
    logic signed [COORD_W-1:0] dst_y;
    logic signed [COORD_W-1:0] dst_z;
    logic                      last_pair;
  } rtis_in_t;

  // Result beat
  typedef struct packed {
    logic                  is_inlier;
    logic [PAIR_IDX_W-1:0] pair_index;
    logic                  set_done;
    logic [TOTAL_W-1:0]    inlier_total;
    logic [SQ_W-1:0]       mean_error;
    logic                  none_found;
    logic [RATIO_W-1:0]    inlier_ratio;
  } rtis_out_t;

  // Classified pair handed from front to back
  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            inlier;
    logic            last;
  } rtis_cls_t;

endpackage

// ----- design/rtis_if.sv -----
// ============================================================================
// rtis_if
// Valid/ready channels for pair beats and result beats.
// ============================================================================
interface rtis_in_if import rtis_pkg::*; ();
  logic     valid;
  logic     ready;
  rtis_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rtis_out_if import rtis_pkg::*; ();
  logic      valid;
  logic      ready;
  rtis_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/rtis_fifo.sv -----
// ============================================================================
// rtis_fifo
// Short queue of classified pairs between the front and back parts.
// ============================================================================
module rtis_fifo import rtis_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  rtis_cls_t push_data,
  input  logic      push_valid,
  output logic      push_ready,
  output rtis_cls_t pop_data,
  output logic      pop_valid,
  input  logic      pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rtis_cls_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- design/rtis_front.sv -----
// ============================================================================
// rtis_front
// Takes pair beats, applies the rigid transform, forms the saturated squared
// distance and classifies the pair against the threshold.
// ============================================================================
module rtis_front import rtis_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  rtis_cfg_t  cfg,
  rtis_in_if.sink    in_ch,
  output rtis_cls_t  cls,
  output logic       cls_valid,
  input  logic       cls_ready
);

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_DIFF, F_SQR, F_SUM} fst_t;

  fst_t                      state_r;
  logic [1:0]                col_r;
  logic signed [COORD_W-1:0] src_r [3];
  logic signed [COORD_W-1:0] dst_r [3];
  logic                      last_r;
  logic signed [ACC_W-1:0]   acc_r [3];
  logic [COORD_W-1:0]        mag_r [3];
  logic [2:0]                big_r;
  logic [PROD_W-1:0]         prod_r [3];

  logic signed [ENTRY_W-1:0]           ent   [3];
  logic signed [ENTRY_W+COORD_W-1:0]   mprod [3];
  logic signed [ACC_W-1:0]             acc_nxt [3];
  logic signed [ACC_W-1:0]             rnd   [3];
  logic signed [DIF_W-1:0]             dif   [3];
  logic [DIF_W-1:0]                    dmag  [3];
  logic [SQSUM_W-1:0]                  sqsum, sqshift;
  logic [SQ_W-1:0]                     sq;

  // one column of the rotation per cycle, one multiplier per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ent[i]     = $signed(cfg.rot[i][ENTRY_W*col_r +: ENTRY_W]);
      mprod[i]   = ent[i] * src_r[col_r];
      acc_nxt[i] = acc_r[i] + ACC_W'(mprod[i]);
    end
  end

  // round to nearest, drop fraction, add shift, subtract target
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = acc_r[i] + ACC_W'(64'd1 << (FRAC_BITS - 1));
      dif[i]  = DIF_W'(rnd[i] >>> FRAC_BITS) + DIF_W'($signed(cfg.shift[i]))
                - DIF_W'(dst_r[i]);
      dmag[i] = dif[i][DIF_W-1] ? DIF_W'(-dif[i]) : DIF_W'(dif[i]);
    end
  end

  // sum of squares, saturated to the squared distance width
  always_comb begin
    sqsum   = SQSUM_W'(prod_r[0]) + SQSUM_W'(prod_r[1]) + SQSUM_W'(prod_r[2]);
    sqshift = sqsum >> FRAC_BITS;
    if ((|big_r) || (|sqshift[SQSUM_W-1:SQ_W])) begin
      sq = '1;
    end else begin
      sq = sqshift[SQ_W-1:0];
    end
  end

  assign cls.sq     = sq;
  assign cls.inlier = (sq <= cfg.max_err_sq);
  assign cls.last   = last_r;
  assign cls_valid  = (state_r == F_SUM);
  assign in_ch.ready = (state_r == F_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            src_r[0] <= in_ch.payload.src_x;
            src_r[1] <= in_ch.payload.src_y;
            src_r[2] <= in_ch.payload.src_z;
            dst_r[0] <= in_ch.payload.dst_x;
            dst_r[1] <= in_ch.payload.dst_y;
            dst_r[2] <= in_ch.payload.dst_z;
            last_r   <= in_ch.payload.last_pair;
            for (int i = 0; i < 3; i++) acc_r[i] <= '0;
            col_r    <= '0;
            state_r  <= F_MUL;
          end
        end
        F_MUL: begin
          for (int i = 0; i < 3; i++) acc_r[i] <= acc_nxt[i];
          col_r <= col_r + 1'b1;
          if (col_r == 2'd2) begin
            state_r <= F_DIFF;
          end
        end
        F_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= dmag[i][COORD_W-1:0];
            big_r[i] <= |dmag[i][DIF_W-1:COORD_W];
          end
          state_r <= F_SQR;
        end
        F_SQR: begin
          for (int i = 0; i < 3; i++) prod_r[i] <= mag_r[i] * mag_r[i];
          state_r <= F_SUM;
        end
        F_SUM: begin
          if (cls_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- design/rtis_sqrt.sv -----
// ============================================================================
// rtis_sqrt
// Integer square root, two operand bits per cycle, floor result.
// ============================================================================
module rtis_sqrt import rtis_pkg::*; #(
  parameter int IN_W = ROOT_IN_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [IN_W-1:0]         value,
  output logic                    done,
  output logic [(IN_W+1)/2-1:0]   root
);

  localparam int RW    = (IN_W + 1) / 2;
  localparam int CNT_W = $clog2(RW + 1);

  logic [2*RW-1:0]  val_r;
  logic [RW:0]      rem_r;
  logic [RW-1:0]    root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [RW+2:0]    rem_t, trial;

  assign rem_t = {rem_r, val_r[2*RW-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign done  = done_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        val_r  <= (2*RW)'(value);
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(RW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // restoring step
        if (rem_t >= trial) begin
          rem_r  <= (RW+1)'(rem_t - trial);
          root_r <= {root_r[RW-2:0], 1'b1};
        end else begin
          rem_r  <= (RW+1)'(rem_t);
          root_r <= {root_r[RW-2:0], 1'b0};
        end
        val_r <= {val_r[2*RW-3:0], 2'b00};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/rtis_div.sv -----
// ============================================================================
// rtis_div
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
module rtis_div import rtis_pkg::*; #(
  parameter int NW = SUM_W,
  parameter int DW = TOTAL_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    num_r;
  logic [DW-1:0]    den_r;
  logic [DW-1:0]    rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DW:0]      rem_t;

  assign rem_t = {rem_r, num_r[NW-1]};
  assign done  = done_r;
  assign quot  = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // quotient bits shift in where dividend bits leave
        if (rem_t >= {1'b0, den_r}) begin
          rem_r <= DW'(rem_t - {1'b0, den_r});
          num_r <= {num_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= DW'(rem_t);
          num_r <= {num_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/rtis_back.sv -----
// ============================================================================
// rtis_back
// Takes classified pairs, accumulates inlier count and distance sum, and on
// the end of a set works out mean error and inlier ratio.
// ============================================================================
module rtis_back import rtis_pkg::*; #(
  parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  rtis_cls_t  cls,
  input  logic       cls_valid,
  output logic       cls_ready,
  rtis_out_if.source out_ch
);

  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int RW = (ROOT_IN_W + 1) / 2;

  typedef enum logic [2:0] {B_IDLE, B_SQRT, B_SUMUP, B_DIVM, B_DIVR, B_EMIT} bst_t;

  bst_t             state_r;
  logic [CW-1:0]    pair_cnt_r, inl_cnt_r, idx_r;
  logic [SUM_W-1:0] err_sum_r;
  logic             inl_r, done_r, none_r;
  logic [SQ_W-1:0]  mean_r;
  logic [RATIO_W-1:0] ratio_r;
  logic             out_valid_r;
  rtis_out_t        out_r;

  logic             sqrt_done;
  logic [RW-1:0]    root;
  logic             div_start, div_mean_sel, div_done;
  logic [SUM_W-1:0] div_num, div_quot;
  logic [CW-1:0]    div_den;
  logic [SUM_W:0]   err_add;
  logic [31:0]      idx_ext, tot_ext;

  assign cls_ready = (state_r == B_IDLE);

  // distance of the popped pair, inliers only
  rtis_sqrt #(.IN_W(ROOT_IN_W)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cls_valid && cls_ready && cls.inlier),
    .value ({cls.sq, {FRAC_BITS{1'b0}}}),
    .done  (sqrt_done),
    .root  (root)
  );

  // shared divider: mean first (skipped when there is no inlier), then ratio
  assign div_start    = ((state_r == B_SUMUP) && done_r) ||
                        ((state_r == B_DIVM) && div_done);
  assign div_mean_sel = (state_r == B_SUMUP) && (inl_cnt_r != '0);
  assign div_num      = div_mean_sel ? err_sum_r
                                     : SUM_W'({inl_cnt_r, {RATIO_SHIFT{1'b0}}});
  assign div_den      = div_mean_sel ? inl_cnt_r : pair_cnt_r;

  rtis_div #(.NW(SUM_W), .DW(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign err_add = {1'b0, err_sum_r} + (SUM_W+1)'(root);
  assign idx_ext = 32'(idx_r);
  assign tot_ext = 32'(inl_cnt_r);

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pair_cnt_r  <= '0;
      inl_cnt_r   <= '0;
      err_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop valid once the sink takes the beat; B_EMIT handles its own
      if (out_ch.ready && (state_r != B_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (cls_valid) begin
            inl_r      <= cls.inlier;
            idx_r      <= pair_cnt_r;
            done_r     <= cls.last || (pair_cnt_r >= CW'(MAX_PAIRS - 1));
            pair_cnt_r <= pair_cnt_r + 1'b1;
            if (cls.inlier) begin
              inl_cnt_r <= inl_cnt_r + 1'b1;
              state_r   <= B_SQRT;
            end else begin
              state_r   <= B_SUMUP;
            end
          end
        end
        B_SQRT: begin
          if (sqrt_done) begin
            err_sum_r <= err_add[SUM_W] ? '1 : err_add[SUM_W-1:0];
            state_r   <= B_SUMUP;
          end
        end
        B_SUMUP: begin
          none_r <= (inl_cnt_r == '0);
          mean_r <= '0;
          if (!done_r) begin
            state_r <= B_EMIT;
          end else if (inl_cnt_r == '0) begin
            state_r <= B_DIVR;
          end else begin
            state_r <= B_DIVM;
          end
        end
        B_DIVM: begin
          if (div_done) begin
            mean_r  <= (|div_quot[SUM_W-1:SQ_W]) ? '1 : div_quot[SQ_W-1:0];
            state_r <= B_DIVR;
          end
        end
        B_DIVR: begin
          if (div_done) begin
            ratio_r <= div_quot[RATIO_W-1:0];
            state_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r        <= 1'b1;
            out_r.is_inlier    <= inl_r;
            out_r.pair_index   <= idx_ext[PAIR_IDX_W-1:0];
            out_r.set_done     <= done_r;
            out_r.inlier_total <= done_r ? tot_ext[TOTAL_W-1:0] : '0;
            out_r.mean_error   <= done_r ? mean_r : '0;
            out_r.none_found   <= done_r ? none_r : 1'b0;
            out_r.inlier_ratio <= done_r ? ratio_r : '0;
            if (done_r) begin
              pair_cnt_r <= '0;
              inl_cnt_r  <= '0;
              err_sum_r  <= '0;
            end
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- design/rigid_transform_inlier_scoring_unit.sv -----
// ============================================================================
// rigid_transform_inlier_scoring_unit
// Scores a rigid transform against a stream of 3D point pairs and reports
// inlier count, mean inlier distance and inlier ratio per set.
// ============================================================================
//   channel  | dir | beat                         | handshake
//   in_ch    | in  | one point pair (src, dst)    | valid/ready
//   out_ch   | out | one result per pair          | valid/ready
//   cfg_*    | in  | register write, no read-back | write enable
//
// The front takes one pair at a time: an accept step, rotation multiplies one
// column at a time (one multiplier per axis), then difference, square, compare.
// The back runs an inlier through a 24-step square root; a set's last pair adds
// 42-step divides for the mean (if there is any inlier) and for the ratio.
// A 2-entry queue decouples the two; an output register holds a result while
// the sink stalls. Reset is synchronous, clears counters and loads default config.
module rigid_transform_inlier_scoring_unit import rtis_pkg::*; #(
  parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rtis_in_if.sink               in_ch,
  rtis_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  rtis_cfg_t cfg_r;
  rtis_cls_t f2q, q2b;
  logic      f2q_valid, f2q_ready, q2b_valid, q2b_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot[0]     <= ROT0_RST;
      cfg_r.rot[1]     <= ROT1_RST;
      cfg_r.rot[2]     <= ROT2_RST;
      cfg_r.shift      <= '0;
      cfg_r.max_err_sq <= MAX_ERR_SQ_RST;
    end else if (cfg_we) begin
      case (rtis_reg_t'(cfg_idx))
        REG_ROT_ROW0:   cfg_r.rot[0]     <= cfg_wdata[ROW_W-1:0];
        REG_ROT_ROW1:   cfg_r.rot[1]     <= cfg_wdata[ROW_W-1:0];
        REG_ROT_ROW2:   cfg_r.rot[2]     <= cfg_wdata[ROW_W-1:0];
        REG_SHIFT_X:    cfg_r.shift[0]   <= cfg_wdata[COORD_W-1:0];
        REG_SHIFT_Y:    cfg_r.shift[1]   <= cfg_wdata[COORD_W-1:0];
        REG_SHIFT_Z:    cfg_r.shift[2]   <= cfg_wdata[COORD_W-1:0];
        REG_MAX_ERR_SQ: cfg_r.max_err_sq <= cfg_wdata[SQ_W-1:0];
        default: ;
      endcase
    end
  end

  rtis_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .cls       (f2q),
    .cls_valid (f2q_valid),
    .cls_ready (f2q_ready)
  );

  rtis_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (f2q),
    .push_valid (f2q_valid),
    .push_ready (f2q_ready),
    .pop_data   (q2b),
    .pop_valid  (q2b_valid),
    .pop_ready  (q2b_ready)
  );

  rtis_back #(.MAX_PAIRS(MAX_PAIRS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls       (q2b),
    .cls_valid (q2b_valid),
    .cls_ready (q2b_ready),
    .out_ch    (out_ch)
  );

endmodule

// ----- tb/rigid_transform_inlier_scoring_unit_tb.sv -----
// ============================================================================
// rigid_transform_inlier_scoring_unit_tb
// Drives point pairs under several transforms and thresholds, predicts each
// result beat from a behavioral scorer and compares every field.
// ============================================================================
module rigid_transform_inlier_scoring_unit_tb;
  import rtis_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int LONG_SET_LEN   = 300;
  localparam logic [63:0] SUM_SAT = 64'h3FF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rtis_in_if  in_ch ();
  rtis_out_if out_ch ();

  rigid_transform_inlier_scoring_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Scorer state and configuration copy
  logic [ROW_W-1:0] sc_rot [3];
  logic signed [63:0] sc_shift [3];
  logic [63:0] sc_thresh;
  int unsigned sc_pairs, sc_inliers;
  logic [63:0] sc_err_sum;

  rtis_out_t score_q [$];
  int errors = 0;
  int beats_seen = 0, sets_seen = 0;
  bit no_idle = 1'b0;
  int idle_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] axis_out(int r, logic signed [63:0] s [3]);
    logic signed [63:0] acc;
    logic signed [17:0] e;
    acc = 0;
    for (int c = 0; c < 3; c++) begin
      e = sc_rot[r][c*ENTRY_W +: ENTRY_W];
      acc += 64'(e) * s[c];
    end
    acc += 64'sd1 << (FRAC_BITS - 1);
    return (acc >>> FRAC_BITS) + sc_shift[r];
  endfunction

  // Predict one result beat and advance the scorer state
  function automatic rtis_out_t score_pair(rtis_in_t p);
    rtis_out_t o;
    logic signed [63:0] s [3], d [3], df;
    logic [63:0] mag, prod, sum, sq, nxt;
    bit inl, done;
    int unsigned idx;
    s[0] = 64'(p.src_x); s[1] = 64'(p.src_y); s[2] = 64'(p.src_z);
    d[0] = 64'(p.dst_x); d[1] = 64'(p.dst_y); d[2] = 64'(p.dst_z);
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      df = axis_out(k, s) - d[k];
      mag = df < 0 ? 64'(-df) : 64'(df);
      prod = mag > 64'hFFFF_FFFF ? '1 : mag * mag;
      nxt = sum + prod;
      sum = nxt < sum ? '1 : nxt;
    end
    sq = sum >> FRAC_BITS;
    if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
    inl = sq <= sc_thresh;
    idx = sc_pairs;
    sc_pairs++;
    if (inl) begin
      sc_inliers++;
      sc_err_sum += int_sqrt(sq << FRAC_BITS);
      if (sc_err_sum > SUM_SAT) sc_err_sum = SUM_SAT;
    end
    done = p.last_pair || idx >= DEF_MAX_PAIRS - 1;
    o = '0;
    o.is_inlier = inl;
    o.pair_index = idx[PAIR_IDX_W-1:0];
    o.set_done = done;
    if (done) begin
      o.inlier_total = sc_inliers[TOTAL_W-1:0];
      if (sc_inliers == 0) o.none_found = 1'b1;
      else begin
        nxt = sc_err_sum / sc_inliers;
        o.mean_error = nxt > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : nxt[31:0];
      end
      nxt = (64'(sc_inliers) << RATIO_SHIFT) / sc_pairs;
      o.inlier_ratio = nxt[RATIO_W-1:0];
      sc_pairs = 0; sc_inliers = 0; sc_err_sum = 0;
    end
    return o;
  endfunction

  // Result checker and sink stall
  always @(posedge clk) begin
    rtis_out_t exp_b;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        beats_seen++;
        if (score_q.size() == 0) begin
          $display("%0t unexpected result beat %h", $time, out_ch.payload);
          errors++;
        end else begin
          exp_b = score_q.pop_front();
          if (exp_b.set_done) sets_seen++;
          if (exp_b.is_inlier !== out_ch.payload.is_inlier ||
              exp_b.pair_index !== out_ch.payload.pair_index ||
              exp_b.set_done !== out_ch.payload.set_done ||
              exp_b.inlier_total !== out_ch.payload.inlier_total ||
              exp_b.mean_error !== out_ch.payload.mean_error ||
              exp_b.none_found !== out_ch.payload.none_found ||
              exp_b.inlier_ratio !== out_ch.payload.inlier_ratio) begin
            $display("%0t mismatch: expected %p actual %p", $time, exp_b,
                     out_ch.payload);
            errors++;
          end
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= 28);
    end
  end

  // Watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("rigid_transform_inlier_scoring_unit_tb failed");
        $finish;
      end
    end
  end

  // valid stays up between back-to-back beats; wait_drain drops it
  task automatic send_pair(rtis_in_t p);
    while (!no_idle && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    score_q = {score_q, score_pair(p)};
  endtask

  // cfg_we stays up between writes; the caller drops it after the last one
  task automatic write_reg(rtis_reg_t r, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_wdata <= v;
    @(posedge clk);
    case (r)
      REG_ROT_ROW0: sc_rot[0] = v;
      REG_ROT_ROW1: sc_rot[1] = v;
      REG_ROT_ROW2: sc_rot[2] = v;
      REG_SHIFT_X: sc_shift[0] = 64'(signed'(v[31:0]));
      REG_SHIFT_Y: sc_shift[1] = 64'(signed'(v[31:0]));
      REG_SHIFT_Z: sc_shift[2] = 64'(signed'(v[31:0]));
      default: sc_thresh = 64'(v[31:0]);
    endcase
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000);
      2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: return 32'($signed($urandom_range(400000)) - 200000);
    endcase
  endfunction

  // Pair near the transformed source so that many are inliers
  function automatic rtis_in_t near_pair(bit last, int jit);
    rtis_in_t p;
    logic signed [63:0] s [3];
    p.src_x = rnd_coord(); p.src_y = rnd_coord(); p.src_z = rnd_coord();
    s[0] = 64'(p.src_x); s[1] = 64'(p.src_y); s[2] = 64'(p.src_z);
    p.dst_x = 32'(axis_out(0, s) + $signed($urandom_range(2*jit)) - jit);
    p.dst_y = 32'(axis_out(1, s) + $signed($urandom_range(2*jit)) - jit);
    p.dst_z = 32'(axis_out(2, s) + $signed($urandom_range(2*jit)) - jit);
    if ($urandom_range(9) == 0) p.dst_x = $urandom();
    p.last_pair = last;
    return p;
  endfunction

  task automatic test_directed();
    rtis_in_t p;
    p = '0; p.last_pair = 1'b1;
    send_pair(p);                                   // one-pair set, exact hit
    p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0};
    send_pair(p);                                   // huge error saturates
    p.last_pair = 1'b1;
    send_pair(p);                                   // set with no inlier
    p = '0; p.dst_x = 32'd3276;                     // just under threshold
    send_pair(p);
    p.dst_x = 32'd3277;
    send_pair(p);
    p = '1;
    send_pair(p);
    wait_drain();
  endtask

  task automatic test_long_set();
    // one long set, with a stretch of beats sent without any idling
    for (int i = 0; i < LONG_SET_LEN; i++) begin
      if (i == 100) no_idle = 1'b1;
      if (i == 250) no_idle = 1'b0;
      send_pair(near_pair(1'b0, 20));
    end
    send_pair(near_pair(1'b1, 20));
    wait_drain();
  endtask

  task automatic test_config_sweep(int sets);
    logic [CFG_DATA_W-1:0] rows [3];
    int len;
    for (int n = 0; n < sets; n++) begin
      case (n % 4)
        0: begin
          rows[0] = {18'h0, 18'h0, 18'h10000};
          rows[1] = {18'h0, 18'h10000, 18'h0};
          rows[2] = {18'h10000, 18'h0, 18'h0};
        end
        1: begin
          rows[0] = {18'h1FFFF, 18'h20000, 18'h1FFFF};
          rows[1] = {18'h20000, 18'h1FFFF, 18'h20000};
          rows[2] = '1;
        end
        2: begin
          rows[0] = {18'h0, 18'h30000, 18'h0};
          rows[1] = {18'h0, 18'h0, 18'h10000};
          rows[2] = {18'h10000, 18'h0, 18'h0};
        end
        default: for (int r = 0; r < 3; r++)
          rows[r] = CFG_DATA_W'({$urandom(), $urandom()});
      endcase
      write_reg(REG_ROT_ROW0, rows[0]);
      write_reg(REG_ROT_ROW1, rows[1]);
      write_reg(REG_ROT_ROW2, rows[2]);
      write_reg(REG_SHIFT_X, CFG_DATA_W'(n % 4 == 1 ? 32'h7FFF_FFFF : rnd_coord()));
      write_reg(REG_SHIFT_Y, CFG_DATA_W'(n % 4 == 1 ? 32'h8000_0000 : rnd_coord()));
      write_reg(REG_SHIFT_Z, CFG_DATA_W'(rnd_coord()));
      write_reg(REG_MAX_ERR_SQ, CFG_DATA_W'(n % 5 == 0 ? 32'hFFFF_FFFF :
                n % 5 == 1 ? 32'h0 : $urandom_range(100000)));
      cfg_we <= 1'b0;
      len = $urandom_range(1, 16);
      for (int i = 0; i < len; i++)
        send_pair(near_pair(i == len - 1, n % 3 == 0 ? 2 : 300));
      wait_drain();
    end
  endtask

  initial begin
    sc_rot[0] = ROT0_RST; sc_rot[1] = ROT1_RST; sc_rot[2] = ROT2_RST;
    for (int k = 0; k < 3; k++) sc_shift[k] = 0;
    sc_thresh = 64'(MAX_ERR_SQ_RST);
    sc_pairs = 0; sc_inliers = 0; sc_err_sum = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep(8);
    test_long_set();
    test_config_sweep(8);
    $display("covered %0d result beats in %0d sets under 16 register settings",
             beats_seen, sets_seen);
    if (errors == 0) $display("rigid_transform_inlier_scoring_unit_tb passed");
    else $display("rigid_transform_inlier_scoring_unit_tb failed");
    $finish;
  end
endmodule
